// ----- sv/eqc_pkg.sv -----
// eqc_pkg: shared constants, codes and the controller-to-datapath command type
// for the multiband IIR equalizer cascade. No dependencies.
package eqc_pkg;

	localparam int IIR_ORDER = 4;
	localparam int COEFS = 2 * IIR_ORDER + 1;
	localparam int HIST = 2 * IIR_ORDER;
	localparam int QSHIFT = 27;

	localparam int DEF_CHANNELS = 8;
	localparam int DEF_BANDS = 8;
	localparam int DEF_SECTIONS = 2;

	typedef logic [1:0] action_t;
	localparam action_t ACT_SAMPLE = 2'd0;
	localparam action_t ACT_COEF = 2'd1;
	localparam action_t ACT_ENABLE = 2'd2;

	typedef struct packed {
		logic       clr;
		logic       issue;
		logic [3:0] k;
		logic       wr_x;
		logic       sec_end;
		logic       load;
		logic       coef_we;
		logic       out_load;
	} eqc_cmd_t;

endpackage

// ----- sv/eqc_if.sv -----
// eqc_in_if / eqc_out_if: valid-ready channels of the equalizer.
// Depends on eqc_pkg for the action type.
interface eqc_in_if import eqc_pkg::*; ();
	logic               valid;
	logic               ready;
	action_t            action;
	logic [2:0]         channel;
	logic [2:0]         band;
	logic               section;
	logic [3:0]         coef_select;
	logic signed [31:0] coef_value;
	logic               band_on;
	logic signed [23:0] sample_in;

	modport source (output valid, action, channel, band, section, coef_select,
		coef_value, band_on, sample_in, input ready);
	modport sink (input valid, action, channel, band, section, coef_select,
		coef_value, band_on, sample_in, output ready);
endinterface

interface eqc_out_if ();
	logic               valid;
	logic               ready;
	logic signed [23:0] sample_out;
	logic [2:0]         out_channel;

	modport source (output valid, sample_out, out_channel, input ready);
	modport sink (input valid, sample_out, out_channel, output ready);
endinterface

// ----- sv/eqc_datapath.sv -----
// eqc_datapath: coefficient and history memories, shared 32x32 MAC pipeline,
// section saturation and output register. Depends on eqc_pkg.
module eqc_datapath import eqc_pkg::*; #(
	parameter int CHANNELS = DEF_CHANNELS,
	parameter int BANDS = DEF_BANDS,
	parameter int SECTIONS = DEF_SECTIONS,
	localparam int NSEC = CHANNELS * BANDS * SECTIONS,
	localparam int SIW = (NSEC > 1) ? $clog2(NSEC) : 1,
	localparam int CA_W = $clog2(NSEC * COEFS)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  eqc_cmd_t           cmd,
	input  logic [SIW-1:0]     sidx,
	input  logic [CA_W-1:0]    clr_addr,
	input  logic [2:0]         channel,
	input  logic [2:0]         band,
	input  logic               section,
	input  logic [3:0]         coef_select,
	input  logic signed [31:0] coef_value,
	input  logic signed [23:0] sample_in,
	output logic signed [23:0] sample_out,
	output logic [2:0]         out_channel
);

	localparam int HA_W = SIW + 3;
	localparam int HDEPTH = NSEC * HIST;

	logic [31:0]        coef_mem [NSEC*COEFS];
	logic signed [31:0] hist_mem [HDEPTH];

	logic               c_we;
	logic [CA_W-1:0]    c_waddr, c_raddr;
	logic [31:0]        c_wdata;
	logic               h_we;
	logic [HA_W-1:0]    h_waddr, h_raddr;
	logic signed [31:0] h_wdata;

	logic signed [31:0] coef_s1, hist_s1;
	logic               valid_s1, valid_s2, first_s2, neg_s2;
	logic [3:0]         k_s1;
	logic signed [63:0] prod_s2, acc_q;
	logic signed [31:0] x_q, op, y;
	logic [2:0]         ch_q;
	logic signed [23:0] sample_q;
	logic [2:0]         out_ch_q;

	assign c_we = cmd.clr | cmd.coef_we;
	assign c_waddr = cmd.clr ? clr_addr : CA_W'(((int'(channel) * BANDS + int'(band))
		* SECTIONS + int'(section)) * COEFS + int'(coef_select));
	assign c_wdata = cmd.clr ? 32'd0 : coef_value;
	assign c_raddr = CA_W'(int'(sidx) * COEFS + int'(cmd.k));
	assign h_raddr = {sidx, 3'(cmd.k - 4'd1)};

	always_comb begin
		h_we = 1'b0;
		h_waddr = {sidx, 3'd0};
		h_wdata = x_q;
		if (cmd.clr) begin
			h_we = int'(clr_addr) < HDEPTH;
			h_waddr = clr_addr[HA_W-1:0];
			h_wdata = 32'sd0;
		end else if (cmd.sec_end) begin
			h_we = 1'b1;
			h_waddr = {sidx, 3'(IIR_ORDER)};
			h_wdata = y;
		end else if (cmd.wr_x) begin
			h_we = 1'b1;
		end else if (valid_s1 && k_s1 != 4'd0 && k_s1 != 4'(IIR_ORDER)
				&& k_s1 != 4'(HIST)) begin
			h_we = 1'b1;
			h_waddr = {sidx, k_s1[2:0]};
			h_wdata = hist_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (c_we)
			coef_mem[c_waddr] <= c_wdata;
		coef_s1 <= coef_mem[c_raddr];
	end

	always_ff @(posedge clk) begin
		if (h_we)
			hist_mem[h_waddr] <= h_wdata;
		hist_s1 <= hist_mem[h_raddr];
	end

	assign op = (k_s1 == 4'd0) ? x_q : hist_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			k_s1 <= 4'd0;
		end else begin
			valid_s1 <= cmd.issue;
			valid_s2 <= valid_s1;
			k_s1 <= cmd.k;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= coef_s1 * op;
		neg_s2 <= k_s1 > 4'(IIR_ORDER);
		first_s2 <= k_s1 == 4'd0;
		if (valid_s2)
			acc_q <= (first_s2 ? 64'sd0 : acc_q) + (neg_s2 ? -prod_s2 : prod_s2);
	end

	// arithmetic shift by QSHIFT, saturate to 32 bits
	always_comb begin
		if (acc_q[63:QSHIFT+31] == {(33-QSHIFT){acc_q[QSHIFT+31]}})
			y = acc_q[QSHIFT+31:QSHIFT];
		else
			y = acc_q[63] ? 32'sh8000_0000 : 32'sh7fff_ffff;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q <= 32'(sample_in);
			ch_q <= channel;
		end else if (cmd.sec_end) begin
			x_q <= y;
		end
		if (cmd.out_load) begin
			out_ch_q <= ch_q;
			if (x_q[31:23] == {9{x_q[23]}})
				sample_q <= x_q[23:0];
			else
				sample_q <= x_q[31] ? 24'sh80_0000 : 24'sh7f_ffff;
		end
	end

	assign sample_out = sample_q;
	assign out_channel = out_ch_q;

endmodule

// ----- sv/eqc_ctrl.sv -----
// eqc_ctrl: sequencer for the equalizer: memory clearing pass, write decode,
// band enables, band/section/tap stepping and output handshake. Depends on eqc_pkg.
module eqc_ctrl import eqc_pkg::*; #(
	parameter int CHANNELS = DEF_CHANNELS,
	parameter int BANDS = DEF_BANDS,
	parameter int SECTIONS = DEF_SECTIONS,
	localparam int NSEC = CHANNELS * BANDS * SECTIONS,
	localparam int SIW = (NSEC > 1) ? $clog2(NSEC) : 1,
	localparam int CA_W = $clog2(NSEC * COEFS)
) (
	input  logic            clk,
	input  logic            arst_n,
	eqc_in_if.sink          din,
	output logic            out_valid,
	input  logic            out_ready,
	output eqc_cmd_t        cmd,
	output logic [SIW-1:0]  sidx,
	output logic [CA_W-1:0] clr_addr
);

	localparam int NB = CHANNELS * BANDS;
	localparam int BIW = (NB > 1) ? $clog2(NB) : 1;
	localparam int BW = (BANDS > 1) ? $clog2(BANDS) : 1;
	localparam int SW = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
	localparam int CLR_LAST = NSEC * COEFS - 1;

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_BAND = 3'd2;
	localparam logic [2:0] S_RUN = 3'd3;
	localparam logic [2:0] S_DRAIN = 3'd4;
	localparam logic [2:0] S_END = 3'd5;
	localparam logic [2:0] S_DONE = 3'd6;

	logic [2:0]      state_q;
	logic [CA_W-1:0] clr_q;
	logic [BIW-1:0]  bi_q;
	logic [BW-1:0]   b_q;
	logic [SW-1:0]   s_q;
	logic [3:0]      k_q;
	logic            d_q;
	logic [NB-1:0]   en_q;
	logic            ov_q;

	logic xfer, ch_ok, band_ok, sec_ok, sel_ok, b_last, s_last;
	logic [BIW-1:0] en_idx;

	assign din.ready = state_q == S_IDLE;
	assign xfer = din.valid && din.ready;
	assign ch_ok = int'(din.channel) < CHANNELS;
	assign band_ok = int'(din.band) < BANDS;
	assign sec_ok = int'(din.section) < SECTIONS;
	assign sel_ok = din.coef_select < 4'(COEFS);
	assign en_idx = BIW'(int'(din.channel) * BANDS + int'(din.band));
	assign b_last = int'(b_q) == BANDS - 1;
	assign s_last = int'(s_q) == SECTIONS - 1;

	assign sidx = SIW'(int'(bi_q) * SECTIONS + int'(s_q));
	assign clr_addr = clr_q;
	assign out_valid = ov_q;

	always_comb begin
		cmd.clr = state_q == S_CLEAR;
		cmd.issue = state_q == S_RUN;
		cmd.k = k_q;
		cmd.wr_x = state_q == S_DRAIN && !d_q;
		cmd.sec_end = state_q == S_END;
		cmd.load = xfer && din.action == ACT_SAMPLE;
		cmd.coef_we = xfer && din.action == ACT_COEF && ch_ok && band_ok && sec_ok && sel_ok;
		cmd.out_load = state_q == S_DONE && (!ov_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			bi_q <= '0;
			b_q <= '0;
			s_q <= '0;
			k_q <= '0;
			d_q <= 1'b0;
			en_q <= '0;
			ov_q <= 1'b0;
		end else begin
			if (ov_q && out_ready)
				ov_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + CA_W'(1);
					if (clr_q == CA_W'(CLR_LAST))
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (xfer) begin
						unique case (din.action)
							ACT_SAMPLE: begin
								if (ch_ok) begin
									bi_q <= BIW'(int'(din.channel) * BANDS);
									b_q <= '0;
									state_q <= S_BAND;
								end else begin
									state_q <= S_DONE;
								end
							end
							ACT_ENABLE: begin
								if (ch_ok && band_ok)
									en_q[en_idx] <= din.band_on;
							end
							default: ;
						endcase
					end
				end
				S_BAND: begin
					if (en_q[bi_q]) begin
						s_q <= '0;
						k_q <= '0;
						state_q <= S_RUN;
					end else if (b_last) begin
						state_q <= S_DONE;
					end else begin
						b_q <= b_q + BW'(1);
						bi_q <= bi_q + BIW'(1);
					end
				end
				S_RUN: begin
					if (k_q == 4'(COEFS - 1)) begin
						d_q <= 1'b0;
						state_q <= S_DRAIN;
					end else begin
						k_q <= k_q + 4'd1;
					end
				end
				S_DRAIN: begin
					if (d_q)
						state_q <= S_END;
					else
						d_q <= 1'b1;
				end
				S_END: begin
					if (!s_last) begin
						s_q <= s_q + SW'(1);
						k_q <= '0;
						state_q <= S_RUN;
					end else if (b_last) begin
						state_q <= S_DONE;
					end else begin
						b_q <= b_q + BW'(1);
						bi_q <= bi_q + BIW'(1);
						state_q <= S_BAND;
					end
				end
				S_DONE: begin
					if (!ov_q || out_ready) begin
						ov_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_run_to_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RUN && k_q == 4'(COEFS - 1)) |=> state_q == S_DRAIN)
		else $error("tap sequence did not enter drain");
	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ov_q) |-> $past(state_q) == S_DONE)
		else $error("result raised outside done");
	a_end_after_mac: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_END) |-> $past(state_q, 3) == S_RUN)
		else $error("section end without full MAC drain");

endmodule

// ----- sv/multiband_iir_equalizer_cascade_top.sv -----
// multiband_iir_equalizer_cascade_top: top level joining controller and datapath.
// Depends on eqc_pkg, eqc_if, eqc_ctrl, eqc_datapath.
//
// din carries one action per transfer: a sample, a coefficient write or a
// band enable write. Writes complete in the transfer cycle and give no result.
// A sample runs through its channel's enabled bands in order on one shared
// 32x32 MAC; each band is first checked for its enable, and each enabled
// section issues its nine taps, then drains the MAC pipeline and writes its
// history; din is held not ready while a sample runs.
// The result goes to an output register on dout; the next action is taken
// while that result waits, and a following sample holds in its final cycle
// until dout takes the earlier one.
// After reset the coefficient and history memories are cleared, one word a
// cycle, over all CHANNELS*BANDS*SECTIONS*9 coefficient addresses (1152 by
// default), during which din is not ready; band enables reset to bypass at once.
module multiband_iir_equalizer_cascade_top import eqc_pkg::*; #(
	parameter int CHANNELS = DEF_CHANNELS,
	parameter int BANDS = DEF_BANDS,
	parameter int SECTIONS = DEF_SECTIONS
) (
	input logic       clk,
	input logic       arst_n,
	eqc_in_if.sink    din,
	eqc_out_if.source dout
);

	localparam int NSEC = CHANNELS * BANDS * SECTIONS;
	localparam int SIW = (NSEC > 1) ? $clog2(NSEC) : 1;
	localparam int CA_W = $clog2(NSEC * COEFS);

	eqc_cmd_t        cmd;
	logic [SIW-1:0]  sidx;
	logic [CA_W-1:0] clr_addr;

	eqc_ctrl #(.CHANNELS(CHANNELS), .BANDS(BANDS), .SECTIONS(SECTIONS)) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.din(din),
		.out_valid(dout.valid),
		.out_ready(dout.ready),
		.cmd(cmd),
		.sidx(sidx),
		.clr_addr(clr_addr)
	);

	eqc_datapath #(.CHANNELS(CHANNELS), .BANDS(BANDS), .SECTIONS(SECTIONS)) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.sidx(sidx),
		.clr_addr(clr_addr),
		.channel(din.channel),
		.band(din.band),
		.section(din.section),
		.coef_select(din.coef_select),
		.coef_value(din.coef_value),
		.sample_in(din.sample_in),
		.sample_out(dout.sample_out),
		.out_channel(dout.out_channel)
	);

endmodule

// ----- verif/multiband_iir_equalizer_cascade_top_tb.sv -----
// Testbench for multiband_iir_equalizer_cascade_top: checks equalized samples against a
// fixed-point cascade predictor. Depends on eqc_pkg, eqc_if and the equalizer RTL.
`timescale 1ns / 1ps

module multiband_iir_equalizer_cascade_top_tb;
	import eqc_pkg::*;

	localparam int NCH = DEF_CHANNELS;
	localparam int NBD = DEF_BANDS;
	localparam int NSC = DEF_SECTIONS;
	localparam int NSEC_ALL = NCH * NBD * NSC;
	localparam int CYCLE_LIMIT = 2000000;

	typedef struct {
		action_t            act;
		logic [2:0]         ch;
		logic [2:0]         bnd;
		logic               sec;
		logic [3:0]         sel;
		logic signed [31:0] cval;
		logic               on;
		logic signed [23:0] smp;
	} eq_item_t;

	typedef struct {
		logic signed [23:0] smp;
		logic [2:0]         ch;
	} eq_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	eqc_in_if  din ();
	eqc_out_if dout ();

	multiband_iir_equalizer_cascade_top i_dut (
		.clk(clk), .arst_n(arst_n), .din(din.sink), .dout(dout.source)
	);

	always #5 clk = ~clk;

	eq_item_t   pending_q[$];
	eq_result_t expected_q[$];
	logic signed [31:0] coef_mem[NSEC_ALL][COEFS];
	logic signed [31:0] hist_mem[NSEC_ALL][HIST];
	logic               band_en[NCH * NBD];
	int errors = 0;
	int n_samples = 0;
	int n_writes = 0;
	int cycles = 0;
	bit hold_off = 1'b0;
	bit stim_done = 1'b0;
	int send_gap = 0;
	int recv_gap = 0;

	function automatic logic signed [31:0] run_sec(int s, logic signed [31:0] x);
		logic signed [63:0] acc;
		logic signed [63:0] sh;
		logic signed [31:0] y;
		acc = 64'(x) * 64'(coef_mem[s][0]);
		for (int k = 0; k < IIR_ORDER; k++) begin
			acc = acc + 64'(coef_mem[s][1 + k]) * 64'(hist_mem[s][k]);
			acc = acc - 64'(coef_mem[s][5 + k]) * 64'(hist_mem[s][IIR_ORDER + k]);
		end
		sh = acc >>> QSHIFT;
		if (sh > 64'sd2147483647) y = 32'sh7fffffff;
		else if (sh < -64'sd2147483648) y = 32'sh80000000;
		else y = sh[31:0];
		for (int k = IIR_ORDER - 1; k > 0; k--) begin
			hist_mem[s][k] = hist_mem[s][k - 1];
			hist_mem[s][IIR_ORDER + k] = hist_mem[s][IIR_ORDER + k - 1];
		end
		hist_mem[s][0] = x;
		hist_mem[s][IIR_ORDER] = y;
		return y;
	endfunction

	task automatic predict_eq(eq_item_t it);
		logic signed [31:0] x;
		eq_result_t r;
		int bi;
		if (it.act == ACT_COEF) begin
			if (it.sel < COEFS)
				coef_mem[(it.ch * NBD + it.bnd) * NSC + it.sec][it.sel] = it.cval;
		end else if (it.act == ACT_ENABLE) begin
			band_en[it.ch * NBD + it.bnd] = it.on;
		end else if (it.act == ACT_SAMPLE) begin
			x = 32'(it.smp);
			for (int b = 0; b < NBD; b++) begin
				bi = it.ch * NBD + b;
				if (band_en[bi])
					for (int s = 0; s < NSC; s++) x = run_sec(bi * NSC + s, x);
			end
			if (x > 32'sd8388607) x = 32'sd8388607;
			else if (x < -32'sd8388608) x = -32'sd8388608;
			r.smp = x[23:0];
			r.ch = it.ch;
			expected_q.push_back(r);
		end
	endtask

	function automatic int rand_gap();
		int p;
		p = $urandom_range(0, 99);
		if (p < 45) return 0;
		if (p < 90) return $urandom_range(1, 4);
		return $urandom_range(10, 80);
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			din.valid <= 1'b0;
			din.action <= ACT_SAMPLE;
			din.channel <= '0;
			din.band <= '0;
			din.section <= 1'b0;
			din.coef_select <= '0;
			din.coef_value <= '0;
			din.band_on <= 1'b0;
			din.sample_in <= '0;
		end else begin
			if (din.valid && din.ready) begin
				predict_eq('{din.action, din.channel, din.band, din.section,
					din.coef_select, din.coef_value, din.band_on, din.sample_in});
				if (din.action == ACT_SAMPLE) n_samples++;
				else n_writes++;
			end
			if (!din.valid || din.ready) begin
				if (send_gap > 0 || hold_off || pending_q.size() == 0) begin
					if (send_gap > 0) send_gap--;
					din.valid <= 1'b0;
				end else begin
					eq_item_t it;
					it = pending_q.pop_front();
					din.valid <= 1'b1;
					din.action <= it.act;
					din.channel <= it.ch;
					din.band <= it.bnd;
					din.section <= it.sec;
					din.coef_select <= it.sel;
					din.coef_value <= it.cval;
					din.band_on <= it.on;
					din.sample_in <= it.smp;
					send_gap = rand_gap();
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dout.ready <= 1'b0;
		end else begin
			cycles++;
			if (dout.valid && dout.ready) begin
				if (expected_q.size() == 0) begin
					errors++;
					if (errors <= 10) $display("unexpected result %0d ch %0d",
						dout.sample_out, dout.out_channel);
				end else begin
					eq_result_t e;
					e = expected_q.pop_front();
					if (e.smp !== dout.sample_out || e.ch !== dout.out_channel) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: exp %0d ch %0d, got %0d ch %0d",
								e.smp, e.ch, dout.sample_out, dout.out_channel);
					end
				end
			end
			if (recv_gap > 0) begin
				recv_gap--;
				dout.ready <= 1'b0;
			end else begin
				dout.ready <= 1'b1;
				if ($urandom_range(0, 3) == 0) recv_gap = rand_gap();
			end
		end
	end

	function automatic eq_item_t mk(action_t a, int ch, int bnd, int sec, int sel,
		logic signed [31:0] cv, bit on, logic signed [23:0] smp);
		eq_item_t it;
		it.act = a; it.ch = 3'(ch); it.bnd = 3'(bnd); it.sec = 1'(sec); it.sel = 4'(sel);
		it.cval = cv; it.on = on; it.smp = smp;
		return it;
	endfunction

	function automatic eq_item_t rand_noise();
		eq_item_t it;
		it.act = action_t'($urandom_range(0, 3));
		it.ch = 3'($urandom); it.bnd = 3'($urandom); it.sec = 1'($urandom);
		it.sel = 4'($urandom); it.cval = $urandom; it.on = 1'($urandom);
		it.smp = 24'($urandom);
		return it;
	endfunction

	// Small random coefficient near a stable filter, occasionally a full-range one.
	function automatic logic signed [31:0] rand_coef(int sel);
		if ($urandom_range(0, 9) == 0) return $urandom;
		if (sel == 0) return 32'sd134217728 + $signed(32'($urandom_range(0, 1 << 24)))
			- 32'sd8388608;
		return $signed(32'($urandom_range(0, 1 << 25))) - 32'sd16777216;
	endfunction

	initial begin
		int ch;
		for (int s = 0; s < NSEC_ALL; s++)
			for (int k = 0; k < COEFS; k++) begin
				coef_mem[s][k] = '0;
				if (k < HIST) hist_mem[s][k] = '0;
			end
		for (int b = 0; b < NCH * NBD; b++) band_en[b] = 1'b0;

		// directed: bypass, extremes, unknown action, out-of-range select
		pending_q.push_back(mk(ACT_SAMPLE, 0, 0, 0, 0, 0, 0, 24'sh7fffff));
		pending_q.push_back(mk(ACT_SAMPLE, 7, 0, 0, 0, 0, 0, 24'sh800000));
		pending_q.push_back(mk(2'd3, 1, 2, 1, 3, 32'sh7fffffff, 1, 24'sh123456));
		pending_q.push_back(mk(ACT_COEF, 0, 0, 0, 0, 32'sh7fffffff, 0, 0));
		pending_q.push_back(mk(ACT_COEF, 0, 0, 0, 9, 32'sh12345678, 0, 0));
		pending_q.push_back(mk(ACT_COEF, 0, 0, 0, 15, 32'sh80000000, 1, 0));
		pending_q.push_back(mk(ACT_ENABLE, 0, 0, 0, 0, 0, 1, 0));
		pending_q.push_back(mk(ACT_SAMPLE, 0, 0, 0, 0, 0, 0, 24'sh7fffff));
		pending_q.push_back(mk(ACT_SAMPLE, 0, 0, 0, 0, 0, 0, 24'sh800000));
		pending_q.push_back(mk(ACT_COEF, 0, 0, 0, 5, 32'sh80000000, 0, 0));
		pending_q.push_back(mk(ACT_COEF, 0, 0, 1, 0, 32'sh80000000, 0, 0));
		pending_q.push_back(mk(ACT_COEF, 0, 0, 1, 8, 32'sh7fffffff, 0, 0));
		pending_q.push_back(mk(ACT_SAMPLE, 0, 0, 0, 0, 0, 0, 24'sh7fffff));
		pending_q.push_back(mk(ACT_SAMPLE, 0, 0, 0, 0, 0, 0, 24'sh800000));
		pending_q.push_back(mk(ACT_SAMPLE, 0, 0, 0, 0, 0, 0, 24'sh000001));
		for (int b = 0; b < NBD; b++)
			pending_q.push_back(mk(ACT_ENABLE, 7, b, 0, 0, 0, 1, 0));
		pending_q.push_back(mk(ACT_SAMPLE, 7, 0, 0, 0, 0, 0, 24'sh7fffff));
		pending_q.push_back(mk(ACT_ENABLE, 0, 0, 0, 0, 0, 0, 0));
		pending_q.push_back(mk(ACT_SAMPLE, 0, 0, 0, 0, 0, 0, 24'sh400000));

		// random: channel set-ups with random content, then sample runs, plus noise
		while (pending_q.size() < 650) begin
			ch = $urandom_range(0, NCH - 1);
			for (int b = 0; b < NBD; b++) begin
				bit on;
				on = ($urandom_range(0, 3) == 0);
				if (on)
					for (int s = 0; s < NSC; s++)
						for (int k = 0; k < COEFS; k++)
							pending_q.push_back(mk(ACT_COEF, ch, b, s, k, rand_coef(k), 0, 0));
				pending_q.push_back(mk(ACT_ENABLE, ch, b, 0, 0, 0, on, 0));
			end
			repeat ($urandom_range(8, 25)) begin
				if ($urandom_range(0, 9) == 0) pending_q.push_back(rand_noise());
				else pending_q.push_back(mk(ACT_SAMPLE, ch, 0, 0, 0, 0, 0, 24'($urandom)));
			end
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// pause the sender until the block drains
		wait (pending_q.size() < 325);
		@(posedge clk);
		hold_off <= 1'b1;
		wait (!din.valid && expected_q.size() == 0);
		repeat (20) @(posedge clk);
		hold_off <= 1'b0;

		wait (pending_q.size() == 0 && !din.valid && expected_q.size() == 0);
		repeat (250) @(posedge clk);
		stim_done = 1'b1;
	end

	initial begin
		wait (stim_done || cycles >= CYCLE_LIMIT);
		if (!stim_done) begin
			$display("timeout after %0d cycles", cycles);
			$display("DONE: errors detected");
			$finish;
		end else begin
			$display("covered %0d samples and %0d writes in %0d cycles, %0d mismatches",
				n_samples, n_writes, cycles, errors);
			if (errors == 0 && expected_q.size() == 0) begin
				$display("DONE: 0 errors");
			end else begin
				$display("DONE: errors detected");
			end
			$finish;
		end
	end

endmodule

// ----- multiband_iir_equalizer_cascade_top.f -----
sv/eqc_pkg.sv
sv/eqc_if.sv
sv/eqc_datapath.sv
sv/eqc_ctrl.sv
sv/multiband_iir_equalizer_cascade_top.sv
verif/multiband_iir_equalizer_cascade_top_tb.sv
